@@ sv/sliding_window_rate_meter_unit_defines.svh @@
// Assertion helpers for the rate meter; clk and arst_n must be in scope.
`ifndef SLIDING_WINDOW_RATE_METER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_RATE_METER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/swrm_pkg.sv @@
package swrm_pkg;

	localparam int SWRM_WINDOWS  = 8;
	localparam int SWRM_TS_W     = 32;
	localparam int SWRM_BYTES_W  = 16;
	localparam int SWRM_PERIOD_W = 16;
	localparam int SWRM_WORD_W   = 32;
	localparam int SWRM_TOT_W    = 40;
	// byte total * 1000 needs 10 more bits
	localparam int SWRM_DVD_W    = 50;
	localparam int SWRM_CNT_W    = 6;
	localparam int SWRM_RATE_W   = 32;

	localparam logic [SWRM_PERIOD_W-1:0] SWRM_PERIOD_RST = 16'd1000;

	typedef struct packed {
		logic busy;
		logic done;
	} swrm_div_stat_t;

endpackage

@@ sv/sliding_window_rate_meter_unit.sv @@
// Sliding-window throughput meter.
// Input channel (in_valid/in_ready) carries one packet event: now_ms and
// byte_count. Output channel (out_valid/out_ready) carries the window rate
// in bytes per second, emitted only when a period closes with a full ring.
// cfg_we/cfg_wdata write period_ms; write only while the block is idle.
// Work per item grows with its path: an item that closes no period is done
// soonest, a period close adds the ring update, and a computed result waits on the
// bit-serial 50-bit divider (one quotient bit per cycle) that forms
// window bytes * 1000 / window milliseconds. in_ready is low while an item
// is in work.
// The result sits in an output register; the next item is accepted while it
// waits. If a new result is ready before the old one is taken, the
// sequencer holds until out_ready frees the register.
// Reset (arst_n low) clears the control state and totals, and sets
// period_ms to 1000; the ring memory is not cleared, since it is read only
// after all WINDOWS entries have been written.
module sliding_window_rate_meter_unit import swrm_pkg::*; #(
	parameter int WINDOWS = SWRM_WINDOWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SWRM_TS_W-1:0]     now_ms,
	input  logic [SWRM_BYTES_W-1:0]  byte_count,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SWRM_RATE_W-1:0]   rate_bytes_per_second,
	input  logic                     cfg_we,
	input  logic [SWRM_PERIOD_W-1:0] cfg_wdata
);

	`include "sliding_window_rate_meter_unit_defines.svh"

	localparam int IDX_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int FILL_W = $clog2(WINDOWS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_SUB  = 4'd3;
	localparam logic [3:0] ST_ADD  = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_DVGO = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]               state_q;
	logic [SWRM_PERIOD_W-1:0] period_q;
	logic                     started_q;
	logic [SWRM_TS_W-1:0]     now_q;
	logic [SWRM_BYTES_W-1:0]  bytes_q;
	logic [SWRM_TS_W-1:0]     pstart_q;
	logic [SWRM_TS_W-1:0]     last_q;
	logic [SWRM_WORD_W-1:0]   pbytes_q;
	logic [SWRM_WORD_W-1:0]   elapsed_q;
	logic                     full_q;
	logic [IDX_W-1:0]         head_q;
	logic [FILL_W-1:0]        fill_q;
	logic [SWRM_TOT_W-1:0]    tbytes_q;
	logic [SWRM_TOT_W-1:0]    tms_q;
	logic [SWRM_DVD_W-1:0]    prod_q;
	logic                     out_valid_q;
	logic [SWRM_RATE_W-1:0]   rate_q;

	logic [SWRM_TS_W-1:0]     ps_eff;
	logic [SWRM_TS_W-1:0]     le_eff;
	logic [SWRM_TS_W-1:0]     gap;
	logic                     gap_hit;
	logic [SWRM_WORD_W-1:0]   pb_base;
	logic [SWRM_TS_W-1:0]     elapsed;
	logic [SWRM_WORD_W-1:0]   rd_bytes;
	logic [SWRM_WORD_W-1:0]   rd_ms;
	logic                     ring_we;
	logic                     div_start;
	logic [SWRM_DVD_W-1:0]    dividend;
	logic [SWRM_RATE_W-1:0]   div_rate;
	swrm_div_stat_t           div_stat;
	logic                     out_free;

	// first event seeds the period start and last-event time
	assign ps_eff  = started_q ? pstart_q : now_q;
	assign le_eff  = started_q ? last_q : now_q;
	assign gap     = now_q - le_eff;
	assign gap_hit = gap >= SWRM_TS_W'({period_q, 2'b00});
	assign pb_base = gap_hit ? '0 : pbytes_q;
	assign elapsed = now_q - pstart_q;

	assign ring_we   = (state_q == ST_ADD);
	assign div_start = (state_q == ST_DVGO);
	// x*1000 = (x << 10) - (x << 4) - (x << 3)
	assign dividend  = {tbytes_q, 10'b0} - prod_q;
	assign out_free  = !out_valid_q || out_ready;

	swrm_ring #(
		.WINDOWS (WINDOWS),
		.IDX_W   (IDX_W)
	) u_ring (
		.clk    (clk),
		.we     (ring_we),
		.waddr  (head_q),
		.wbytes (pbytes_q),
		.wms    (elapsed_q),
		.raddr  (head_q),
		.rbytes (rd_bytes),
		.rms    (rd_ms)
	);

	swrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (tms_q),
		.stat     (div_stat),
		.rate     (div_rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= SWRM_PERIOD_RST;
			started_q   <= 1'b0;
			pstart_q    <= '0;
			last_q      <= '0;
			pbytes_q    <= '0;
			full_q      <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
			tbytes_q    <= '0;
			tms_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			// ST_OUT drives out_valid_q itself
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					started_q <= 1'b1;
					pstart_q  <= gap_hit ? now_q : ps_eff;
					pbytes_q  <= pb_base + SWRM_WORD_W'(bytes_q);
					last_q    <= now_q;
					state_q   <= ST_CHK;
				end
				ST_CHK: begin
					full_q  <= (fill_q == FILL_W'(WINDOWS));
					state_q <= (elapsed >= SWRM_TS_W'(period_q)) ? ST_SUB : ST_IDLE;
				end
				ST_SUB: begin
					// drop the oldest entry from the totals when the ring is full
					if (full_q) begin
						tbytes_q <= tbytes_q - SWRM_TOT_W'(rd_bytes);
						tms_q    <= tms_q - SWRM_TOT_W'(rd_ms);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					tbytes_q <= tbytes_q + SWRM_TOT_W'(pbytes_q);
					tms_q    <= tms_q + SWRM_TOT_W'(elapsed_q);
					head_q   <= (head_q == IDX_W'(WINDOWS - 1)) ? '0 : head_q + 1'b1;
					if (!full_q) begin
						fill_q <= fill_q + 1'b1;
					end
					pstart_q <= now_q;
					pbytes_q <= '0;
					state_q  <= full_q ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_DVGO;
				end
				ST_DVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q   <= now_ms;
			bytes_q <= byte_count;
		end
		if (state_q == ST_CHK) begin
			elapsed_q <= elapsed;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {6'b0, tbytes_q, 4'b0} + {7'b0, tbytes_q, 3'b0};
		end
		if (state_q == ST_OUT && out_free) begin
			rate_q <= div_rate;
		end
	end

	assign in_ready              = (state_q == ST_IDLE);
	assign out_valid             = out_valid_q;
	assign rate_bytes_per_second = rate_q;

	`SWRM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(WINDOWS), "ring fill exceeds depth")
	`SWRM_ASSERT_NOW(a_head_tracks_fill, fill_q < FILL_W'(WINDOWS), FILL_W'(head_q) == fill_q, "head and fill disagree while filling")
	`SWRM_ASSERT_NOW(a_done_in_div, div_stat.done, state_q == ST_DIV, "divider finished outside wait state")
	`SWRM_ASSERT_NEXT(a_start_busy, div_start, div_stat.busy && !in_ready, "divider not running after start")

endmodule

@@ sv/swrm_ring.sv @@
module swrm_ring import swrm_pkg::*; #(
	parameter int WINDOWS = SWRM_WINDOWS,
	parameter int IDX_W   = 3
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [IDX_W-1:0]       waddr,
	input  logic [SWRM_WORD_W-1:0] wbytes,
	input  logic [SWRM_WORD_W-1:0] wms,
	input  logic [IDX_W-1:0]       raddr,
	output logic [SWRM_WORD_W-1:0] rbytes,
	output logic [SWRM_WORD_W-1:0] rms
);

	logic [2*SWRM_WORD_W-1:0] mem [WINDOWS];
	logic [2*SWRM_WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wbytes, wms};
		end
		rdata_q <= mem[raddr];
	end

	assign rbytes = rdata_q[2*SWRM_WORD_W-1:SWRM_WORD_W];
	assign rms    = rdata_q[SWRM_WORD_W-1:0];

endmodule

@@ sv/swrm_div.sv @@
module swrm_div import swrm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SWRM_DVD_W-1:0]  dividend,
	input  logic [SWRM_TOT_W-1:0]  divisor,
	output swrm_div_stat_t         stat,
	output logic [SWRM_RATE_W-1:0] rate
);

	logic                  busy_q;
	logic                  done_q;
	logic [SWRM_CNT_W-1:0] cnt_q;
	logic [SWRM_TOT_W-1:0] rem_q;
	logic [SWRM_TOT_W-1:0] div_q;
	logic [SWRM_DVD_W-1:0] quo_q;

	logic [SWRM_TOT_W:0]   shifted;
	logic [SWRM_TOT_W+1:0] diff;
	logic                  qbit;

	// one restoring step per cycle, MSB first
	assign shifted = {rem_q, quo_q[SWRM_DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};
	assign qbit    = ~diff[SWRM_TOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SWRM_CNT_W'(SWRM_DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[SWRM_TOT_W-1:0] : shifted[SWRM_TOT_W-1:0];
			quo_q <= {quo_q[SWRM_DVD_W-2:0], qbit};
		end
	end

	// zero divisor yields an all-ones quotient, which saturates as required
	assign rate = (|quo_q[SWRM_DVD_W-1:SWRM_RATE_W]) ? '1 : quo_q[SWRM_RATE_W-1:0];

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ test/sliding_window_rate_meter_unit_tb.sv @@
module sliding_window_rate_meter_unit_tb import swrm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [SWRM_TS_W-1:0]    ts;
		logic [SWRM_BYTES_W-1:0] nbytes;
	} packet_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [SWRM_TS_W-1:0]     now_ms = '0;
	logic [SWRM_BYTES_W-1:0]  byte_count = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SWRM_RATE_W-1:0]   rate_bytes_per_second;
	logic                     cfg_we = 1'b0;
	logic [SWRM_PERIOD_W-1:0] cfg_wdata = '0;

	packet_t                packet_q[$];
	logic [SWRM_RATE_W-1:0] pending_rates[$];
	logic [SWRM_TS_W-1:0]   gen_ts = '0;
	bit                     idle_en = 1'b1;
	int unsigned            in_gap = 0;
	int unsigned            out_gap = 0;
	int unsigned            fails = 0;

	// predictor state
	logic [SWRM_PERIOD_W-1:0] period_cfg = SWRM_PERIOD_RST;
	logic                     seen_first = 1'b0;
	logic [SWRM_WORD_W-1:0]   period_start = '0;
	logic [SWRM_WORD_W-1:0]   last_event = '0;
	logic [SWRM_WORD_W-1:0]   period_acc = '0;
	logic [SWRM_WORD_W-1:0]   ring_bytes[SWRM_WINDOWS];
	logic [SWRM_WORD_W-1:0]   ring_ms[SWRM_WINDOWS];
	int unsigned              ring_head = 0;
	int unsigned              ring_fill = 0;
	logic [SWRM_TOT_W-1:0]    sum_bytes = '0;
	logic [SWRM_TOT_W-1:0]    sum_ms = '0;

	sliding_window_rate_meter_unit #(
		.WINDOWS(SWRM_WINDOWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rate_bytes_per_second(rate_bytes_per_second),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the window state by one packet and queues the rate it yields, if any.
	function automatic void track_event_rate(input logic [SWRM_TS_W-1:0] now,
			input logic [SWRM_BYTES_W-1:0] nbytes);
		logic [SWRM_WORD_W-1:0] gap_lim;
		logic [SWRM_WORD_W-1:0] elapsed;
		logic [63:0]            quot;
		logic [SWRM_RATE_W-1:0] rate;
		logic                   was_full;
		int unsigned            slot;
		gap_lim = {14'd0, period_cfg, 2'b00};
		if (!seen_first) begin
			seen_first = 1'b1;
			period_start = now;
			last_event = now;
		end
		if (now - last_event >= gap_lim) begin
			period_start = now;
			period_acc = '0;
		end
		period_acc = period_acc + {16'd0, nbytes};
		elapsed = now - period_start;
		if (elapsed >= {16'd0, period_cfg}) begin
			slot = ring_head;
			was_full = (ring_fill == SWRM_WINDOWS);
			if (was_full) begin
				sum_bytes = sum_bytes - {8'd0, ring_bytes[slot]};
				sum_ms = sum_ms - {8'd0, ring_ms[slot]};
			end else
				ring_fill++;
			ring_bytes[slot] = period_acc;
			ring_ms[slot] = elapsed;
			ring_head = (slot + 1) % SWRM_WINDOWS;
			sum_bytes = sum_bytes + {8'd0, period_acc};
			sum_ms = sum_ms + {8'd0, elapsed};
			if (was_full) begin
				if (sum_ms == '0)
					rate = '1;
				else begin
					quot = ({24'd0, sum_bytes} * 64'd1000) / {24'd0, sum_ms};
					rate = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
				end
				pending_rates.insert(pending_rates.size(), rate);
			end
			period_start = now;
			period_acc = '0;
		end
		last_event = now;
	endfunction

	always @(posedge clk) begin
		packet_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready)
				track_event_rate(now_ms, byte_count);
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (packet_q.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else if (packet_q.size() != 0) begin
					nxt = packet_q.pop_front();
					in_valid <= 1'b1;
					now_ms <= nxt.ts;
					byte_count <= nxt.nbytes;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		logic [SWRM_RATE_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_rates.size() == 0) begin
					$error("rate_bytes_per_second: no result expected, actual %0d",
						rate_bytes_per_second);
					fails++;
				end else begin
					want = pending_rates.pop_front();
					if (rate_bytes_per_second !== want) begin
						$error("rate_bytes_per_second: expected %0d, actual %0d",
							want, rate_bytes_per_second);
						fails++;
					end
				end
			end
			if (out_gap != 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic add_packet(input logic [SWRM_TS_W-1:0] ts,
			input logic [SWRM_BYTES_W-1:0] nbytes);
		packet_t p;
		p.ts = ts;
		p.nbytes = nbytes;
		packet_q.insert(packet_q.size(), p);
		gen_ts = ts;
	endtask

	// period_ms may only change once the meter has gone quiet
	task automatic set_period(input logic [SWRM_PERIOD_W-1:0] per);
		do
			@(negedge clk);
		while (packet_q.size() != 0 || in_valid || pending_rates.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= per;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_cfg = per;
	endtask

	task automatic random_phase(input logic [SWRM_PERIOD_W-1:0] per, input int unsigned count);
		logic [SWRM_WORD_W-1:0]  step_max;
		logic [SWRM_WORD_W-1:0]  gap_lim;
		logic [SWRM_BYTES_W-1:0] nb;
		int unsigned             kind;
		int unsigned             pick;
		step_max = (per == '0) ? 32'd50 : {16'd0, per};
		gap_lim = {14'd0, per, 2'b00};
		repeat (count) begin
			pick = $urandom_range(0, 9);
			nb = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
			kind = $urandom_range(0, 99);
			if (kind < 55)
				add_packet(gen_ts + $urandom_range(0, step_max), nb);
			else if (kind < 65)
				add_packet(gen_ts, nb);
			else if (kind < 71)
				// right at the restart threshold
				add_packet(gen_ts + gap_lim - $urandom_range(0, 1), nb);
			else if (kind < 79)
				add_packet(gen_ts + gap_lim + $urandom_range(0, 2 * step_max), nb);
			else if (kind < 88)
				add_packet($urandom, nb);
			else
				add_packet(gen_ts - $urandom_range(1, step_max + 5), nb);
		end
	endtask

	initial begin
		logic [SWRM_PERIOD_W-1:0] rnd_per;
		int unsigned              wait_cnt;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset period of 1000 ms; first periods straddle the timestamp wrap
		add_packet(32'hFFFF_FE0C, 16'h0000);
		add_packet(gen_ts + 32'd999, 16'hFFFF);
		add_packet(gen_ts + 32'd1, 16'h0001);
		for (int k = 0; k < 8; k++)
			add_packet(gen_ts + 32'd1000, k[0] ? 16'hFFFF : 16'h5A5A);
		add_packet(gen_ts + 32'd3999, 16'h1234);
		add_packet(gen_ts + 32'd4000, 16'hFFFF);
		add_packet(gen_ts + 32'd1500, 16'h0000);

		// zero period: every item closes an empty-length period
		set_period(16'd0);
		add_packet(gen_ts + 32'd3, 16'hFFFF);
		add_packet(gen_ts, 16'hFFFF);
		add_packet(gen_ts - 32'd2, 16'hFFFF);
		add_packet(32'h0000_0000, 16'hFFFF);
		add_packet(32'hFFFF_FFFF, 16'hFFFF);
		repeat (5)
			add_packet(gen_ts + 32'd1, 16'hFFFF);

		// heavy burst into one 1 ms period against a ring of zero-length entries
		set_period(16'd1);
		repeat (70)
			add_packet(gen_ts, 16'hFFFF);
		add_packet(gen_ts + 32'd1, 16'hFFFF);
		random_phase(16'd1, 265);

		set_period(16'hFFFF);
		random_phase(16'hFFFF, 265);
		set_period(16'd3);
		random_phase(16'd3, 265);
		set_period(16'd0);
		random_phase(16'd0, 265);
		set_period(16'd250);
		random_phase(16'd250, 265);
		set_period(16'd1000);
		random_phase(16'd1000, 265);

		rnd_per = 16'($urandom_range(2, 5000));
		set_period(rnd_per);
		idle_en = 1'b0;
		random_phase(rnd_per, 265);

		do
			@(negedge clk);
		while (packet_q.size() != 0 || in_valid);
		for (wait_cnt = 0; wait_cnt < 5000 && pending_rates.size() != 0; wait_cnt++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_rates.size() != 0) begin
			$error("rate_bytes_per_second: %0d expected results never came out",
				pending_rates.size());
			fails++;
		end
		if (fails == 0)
			$display("sliding_window_rate_meter_unit test passed");
		else
			$display("sliding_window_rate_meter_unit test failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("sliding_window_rate_meter_unit test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/swrm_pkg.sv
sv/swrm_ring.sv
sv/swrm_div.sv
sv/sliding_window_rate_meter_unit.sv
test/sliding_window_rate_meter_unit_tb.sv
